// ===== hw/rtl/otf_pkg.sv =====
// Shared types and constants for the Otsu threshold finder.
package otf_pkg;

  localparam int PIX_W = 8;
  localparam int CNT_W = 21;
  localparam int SUM_W = 29;
  localparam int PP_W  = 50;
  localparam int DIF_W = 49;
  localparam int DEN_W = 42;
  localparam int SQ_W  = 98;
  localparam int CMP_W = 140;
  localparam int PRD_W = 147;
  localparam int BINS  = 256;
  localparam logic [PIX_W-1:0] LVL_LAST = PIX_W'(BINS - 1);

  typedef enum logic [1:0] {
    MUL_SQ,
    MUL_LHS,
    MUL_RHS
  } mul_sel_t;

  typedef struct packed {
    logic             accept_en;
    logic             clr;
    logic [PIX_W-1:0] lvl;
    logic             sweep_init;
    logic             upd;
    logic             prod;
    logic             diff;
    logic             mul_start;
    mul_sel_t         mul_sel;
    logic             save_sq;
    logic             save_lhs;
    logic             take_first;
    logic             take_cmp;
    logic             out_load;
  } cmd_t;

  typedef struct packed {
    logic last_fire;
    logic eval;
    logic mul_busy;
    logic bden_zero;
    logic out_full;
  } sts_t;

endpackage

// ===== hw/rtl/otf_mul.sv =====
// Iterative shift-add multiplier, one multiplier bit per cycle.
module otf_mul import otf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SQ_W-1:0]  a,
  input  logic [DIF_W-1:0] b,
  output logic             busy,
  output logic [PRD_W-1:0] p
);

  logic             busy_r;
  logic [PRD_W-1:0] a_r;
  logic [DIF_W-1:0] b_r;
  logic [PRD_W-1:0] acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && b_r == '0) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= PRD_W'(a);
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r && b_r != '0) begin
      acc_r <= acc_r + (b_r[0] ? a_r : '0);
      a_r   <= a_r << 1;
      b_r   <= b_r >> 1;
    end
  end

  assign busy = busy_r;
  assign p    = acc_r;

endmodule

// ===== hw/rtl/otf_dp.sv =====
// Datapath: histogram memory, frame totals, sweep arithmetic and result register.
module otf_dp import otf_pkg::*; #(
  parameter int MAX_PIXELS = 1048576
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  output sts_t             sts,
  input  logic             in_valid,
  input  logic [PIX_W-1:0] in_pixel,
  input  logic             in_last_pixel,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [PIX_W-1:0] out_threshold
);

  logic [CNT_W-1:0] mem [BINS];
  logic [CNT_W-1:0] rd_r;

  logic             b_vld_r;
  logic [PIX_W-1:0] b_pix_r;
  logic             wr_vld_r;
  logic [PIX_W-1:0] wr_pix_r;
  logic [CNT_W-1:0] wr_val_r;

  logic [CNT_W-1:0] pix_total_r;
  logic [SUM_W-1:0] int_total_r;

  logic             running_r;
  logic [CNT_W-1:0] wb_r;
  logic [CNT_W-1:0] wf_r;
  logic [SUM_W-1:0] bsum_r;
  logic [PP_W-1:0]  p1_r;
  logic [PP_W-1:0]  p2_r;
  logic [DEN_W-1:0] den_r;
  logic [DIF_W-1:0] mag_r;
  logic [SQ_W-1:0]  sq_r;
  logic [CMP_W-1:0] lhs_r;
  logic [SQ_W-1:0]  best_sq_r;
  logic [DEN_W-1:0] best_den_r;
  logic [PIX_W-1:0] best_lvl_r;

  logic             out_valid_r;
  logic [PIX_W-1:0] out_thr_r;

  logic             fire;
  logic             cnt_ok;
  logic [CNT_W-1:0] base;
  logic             mem_we;
  logic [PIX_W-1:0] mem_wa;
  logic [CNT_W-1:0] mem_wd;
  logic [PIX_W-1:0] mem_ra;
  logic [CNT_W-1:0] wb_nxt;
  logic [CNT_W-1:0] wf_nxt;
  logic             mul_start;
  logic [SQ_W-1:0]  mul_a;
  logic [DIF_W-1:0] mul_b;
  logic             mul_busy;
  logic [PRD_W-1:0] mul_p;
  logic             better;

  assign fire   = in_valid && cmd.accept_en;
  assign cnt_ok = pix_total_r < CNT_W'(MAX_PIXELS);
  assign base   = (wr_vld_r && wr_pix_r == b_pix_r) ? wr_val_r : rd_r;
  assign mem_we = cmd.clr || b_vld_r;
  assign mem_wa = cmd.clr ? cmd.lvl : b_pix_r;
  assign mem_wd = cmd.clr ? '0 : base + CNT_W'(1);
  assign mem_ra = cmd.accept_en ? in_pixel : cmd.lvl;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r     <= 1'b0;
      wr_vld_r    <= 1'b0;
      pix_total_r <= '0;
      int_total_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      b_vld_r <= fire && cnt_ok;
      if (cmd.clr) begin
        wr_vld_r <= 1'b0;
      end else if (b_vld_r) begin
        wr_vld_r <= 1'b1;
      end
      if (cmd.out_load) begin
        pix_total_r <= '0;
        int_total_r <= '0;
      end else if (fire && cnt_ok) begin
        pix_total_r <= pix_total_r + CNT_W'(1);
        int_total_r <= int_total_r + SUM_W'(in_pixel);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      b_pix_r <= in_pixel;
    end
    if (b_vld_r && !cmd.clr) begin
      wr_pix_r <= b_pix_r;
      wr_val_r <= mem_wd;
    end
    if (cmd.out_load) begin
      out_thr_r <= best_lvl_r;
    end
  end

  assign wb_nxt = wb_r + rd_r;
  assign wf_nxt = pix_total_r - wb_nxt;

  always_ff @(posedge clk) begin
    if (cmd.sweep_init) begin
      running_r  <= 1'b1;
      wb_r       <= '0;
      bsum_r     <= '0;
      best_sq_r  <= '0;
      best_den_r <= '0;
      best_lvl_r <= '0;
    end else begin
      if (cmd.upd && running_r) begin
        wb_r <= wb_nxt;
        wf_r <= wf_nxt;
        if (wb_nxt != '0 && wf_nxt == '0) begin
          running_r <= 1'b0;
        end
        if (wb_nxt != '0 && wf_nxt != '0) begin
          bsum_r <= bsum_r + SUM_W'(cmd.lvl * rd_r);
        end
      end
      if (better) begin
        best_sq_r  <= sq_r;
        best_den_r <= den_r;
        best_lvl_r <= cmd.lvl;
      end
    end
    if (cmd.prod) begin
      p1_r  <= PP_W'(bsum_r * pix_total_r);
      p2_r  <= PP_W'(int_total_r * wb_r);
      den_r <= DEN_W'(wb_r * wf_r);
    end
    if (cmd.diff) begin
      mag_r <= (p1_r >= p2_r) ? DIF_W'(p1_r - p2_r) : DIF_W'(p2_r - p1_r);
    end
    if (cmd.save_sq) begin
      sq_r <= mul_p[SQ_W-1:0];
    end
    if (cmd.save_lhs) begin
      lhs_r <= mul_p[CMP_W-1:0];
    end
  end

  assign better = (cmd.take_first && mag_r != '0) ||
                  (cmd.take_cmp && lhs_r > mul_p[CMP_W-1:0]);

  always_comb begin
    mul_start = cmd.mul_start;
    case (cmd.mul_sel)
      MUL_SQ: begin
        mul_a = SQ_W'(mag_r);
        mul_b = mag_r;
      end
      MUL_LHS: begin
        mul_a = sq_r;
        mul_b = DIF_W'(best_den_r);
      end
      MUL_RHS: begin
        mul_a = best_sq_r;
        mul_b = DIF_W'(den_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  otf_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .p     (mul_p)
  );

  assign sts.last_fire = fire && in_last_pixel;
  assign sts.eval      = running_r && wb_nxt != '0 && wf_nxt != '0;
  assign sts.mul_busy  = mul_busy;
  assign sts.bden_zero = best_den_r == '0;
  assign sts.out_full  = out_valid_r && !out_ready;

  assign out_valid     = out_valid_r;
  assign out_threshold = out_thr_r;

endmodule

// ===== hw/rtl/otf_ctrl.sv =====
// Controller: reset clear pass, frame accumulation and per-level sweep sequencing.
module otf_ctrl import otf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_CLR, S_ACC, S_DRAIN, S_RD, S_UPD, S_PROD, S_DIFF, S_SQ, S_SQW,
    S_DEC, S_LHSW, S_RHS, S_RHSW, S_NXT, S_FIN
  } state_t;

  state_t           state_r, state_nxt;
  logic [PIX_W-1:0] lvl_r, lvl_nxt;

  always_comb begin
    state_nxt = state_r;
    lvl_nxt   = lvl_r;
    cmd       = '0;
    cmd.lvl   = lvl_r;
    cmd.mul_sel = MUL_SQ;
    case (state_r)
      S_CLR: begin
        cmd.clr = 1'b1;
        lvl_nxt = lvl_r + PIX_W'(1);
        if (lvl_r == LVL_LAST) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        cmd.accept_en = 1'b1;
        if (sts.last_fire) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd.sweep_init = 1'b1;
        lvl_nxt = '0;
        state_nxt = S_RD;
      end
      S_RD: begin
        cmd.clr = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd = 1'b1;
        state_nxt = sts.eval ? S_PROD : S_NXT;
      end
      S_PROD: begin
        cmd.prod = 1'b1;
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff = 1'b1;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel = MUL_SQ;
        state_nxt = S_SQW;
      end
      S_SQW: begin
        if (!sts.mul_busy) begin
          cmd.save_sq = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.bden_zero) begin
          cmd.take_first = 1'b1;
          state_nxt = S_NXT;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel = MUL_LHS;
          state_nxt = S_LHSW;
        end
      end
      S_LHSW: begin
        if (!sts.mul_busy) begin
          cmd.save_lhs = 1'b1;
          state_nxt = S_RHS;
        end
      end
      S_RHS: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel = MUL_RHS;
        state_nxt = S_RHSW;
      end
      S_RHSW: begin
        if (!sts.mul_busy) begin
          cmd.take_cmp = 1'b1;
          state_nxt = S_NXT;
        end
      end
      S_NXT: begin
        if (lvl_r == LVL_LAST) begin
          state_nxt = S_FIN;
        end else begin
          lvl_nxt = lvl_r + PIX_W'(1);
          state_nxt = S_RD;
        end
      end
      S_FIN: begin
        if (!sts.out_full) begin
          cmd.out_load = 1'b1;
          state_nxt = S_ACC;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      lvl_r   <= '0;
    end else begin
      state_r <= state_nxt;
      lvl_r   <= lvl_nxt;
    end
  end

endmodule

// ===== hw/rtl/otsu_threshold_finder_unit.sv =====
// Otsu threshold finder for 8-bit grey frames.
// Input channel: in_valid/in_ready carry one request per pixel (in_pixel) with
// in_last_pixel marking the end of a frame. Pixels are taken one per cycle;
// the 256-bin histogram update is a read-modify-write with write forwarding.
// After the last pixel the block stops taking requests and sweeps all 256
// bins, clearing each as it is read. A skipped level passes only its read,
// update and next states; an evaluated level adds the exact variance compare,
// which goes through one shift-add multiplier, one bit per cycle, with up to
// three products per level. That multiplier sets most of the sweep time.
// Output channel: out_valid/out_ready carry one threshold per frame. The result
// sits in an output register; a new frame is accepted while it waits, and only
// the end of the next sweep holds if the receiver still stalls.
// Reset: a clearing pass over all 256 bins zeroes the histogram, with in_ready low.
module otsu_threshold_finder_unit import otf_pkg::*; #(
  parameter int MAX_PIXELS = 1048576
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [PIX_W-1:0] in_pixel,
  input  logic             in_last_pixel,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [PIX_W-1:0] out_threshold
);

  cmd_t cmd;
  sts_t sts;

  otf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  otf_dp #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_valid      (in_valid),
    .in_pixel      (in_pixel),
    .in_last_pixel (in_last_pixel),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_threshold (out_threshold)
  );

  assign in_ready = cmd.accept_en;

`ifndef ASSERT_OFF
  a_mul_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_start |-> !sts.mul_busy)
    else $error("multiplier restarted while busy");

  a_last_stops_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last_pixel) |=> !in_ready)
    else $error("input taken during sweep");

  a_no_load_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid && !out_ready))
    else $error("result overwritten while stalled");

  a_ready_mul_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !sts.mul_busy)
    else $error("multiplier busy during accumulation");
`endif

endmodule
